### rtl/tvn_pkg.sv
package tvn_pkg;

	// Register indexes on the configuration port
	typedef enum logic [7:0] {
		CFG_RESOLUTION = 8'd0,
		CFG_PERIOD     = 8'd1
	} cfg_idx_t;

	localparam int RES_W    = 9;
	localparam int PER_W    = 7;
	localparam int COORD_W  = 8;
	localparam int POS_W    = COORD_W + PER_W;  // scaled position
	localparam int FRAC_W   = 16;
	localparam int QUO_W    = POS_W + FRAC_W;   // cell and fraction together
	localparam int CELL_W   = PER_W;            // cell index is below the period
	localparam int WGT_W    = FRAC_W + 1;
	localparam int VAL_W    = 32;               // corner and blend values, Q2.30

	localparam logic [RES_W-1:0] RES_RESET = 9'd64;
	localparam logic [PER_W-1:0] PER_RESET = 7'd4;

	// Lattice hash constants
	localparam logic [14:0] HASH_MUL_Y = 15'd57;
	localparam logic [14:0] HASH_MUL_Z = 15'd113;
	localparam int          HASH_SHIFT = 13;
	localparam logic [13:0] HASH_MUL_SQ = 14'd15731;
	localparam logic [31:0] HASH_ADD_SQ = 32'd789221;
	localparam logic [31:0] HASH_ADD_T  = 32'd1376312589;
	localparam logic [31:0] ONE_Q30     = 32'h4000_0000;

	// Smoothstep: 3 in Q2.16
	localparam logic [17:0] THREE_Q16 = 18'd196608;

	// Pipeline depth from request accept to result register
	localparam int LAT = 21;

	typedef struct packed {
		logic [COORD_W-1:0] voxel_x;
		logic [COORD_W-1:0] voxel_y;
		logic [COORD_W-1:0] voxel_z;
	} vox_t;

	typedef struct packed {
		logic [7:0] noise_byte;
		logic       out_of_range;
	} noise_t;

endpackage

### rtl/tvn_div.sv
module tvn_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [tvn_pkg::POS_W-1:0]   num,
	input  logic [tvn_pkg::RES_W-1:0]   den,
	output logic [tvn_pkg::QUO_W-1:0]   quo
);
	import tvn_pkg::*;

	// Restoring division of num * 2^16 by den, up to four quotient bits per stage
	localparam int STEP = 4;
	localparam int NSTG = (QUO_W + STEP - 1) / STEP;

	logic [RES_W-1:0] rem_s [NSTG];
	logic [QUO_W:0]   quo_s [NSTG];
	logic [POS_W-1:0] num_s [NSTG];

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		logic [RES_W-1:0] rem_in;
		logic [QUO_W:0]   quo_in;
		logic [POS_W-1:0] num_in;
		logic [RES_W-1:0] rem_nx;
		logic [QUO_W:0]   quo_nx;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = num;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign num_in = num_s[k-1];
		end

		always_comb begin
			logic [RES_W:0] trial;
			logic [QUO_W:0] dvd;
			int             idx;
			dvd    = {1'b0, num_in, {FRAC_W{1'b0}}};
			rem_nx = rem_in;
			quo_nx = quo_in;
			trial  = '0;
			for (int j = 0; j < STEP; j++) begin
				idx = QUO_W - 1 - STEP * k - j;
				if (idx >= 0) begin
					trial = {rem_nx, dvd[idx[4:0]]};
					if (trial >= {1'b0, den}) begin
						rem_nx = RES_W'(trial - {1'b0, den});
						quo_nx[idx[4:0]] = 1'b1;
					end else begin
						rem_nx = trial[RES_W-1:0];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= rem_nx;
				quo_s[k] <= quo_nx;
				num_s[k] <= num_in;
			end
		end
	end

	assign quo = quo_s[NSTG-1][QUO_W-1:0];

endmodule

### rtl/tvn_hash.sv
module tvn_hash (
	input  logic                              clk,
	input  logic                              en,
	input  logic [tvn_pkg::CELL_W-1:0]        x,
	input  logic [tvn_pkg::CELL_W-1:0]        y,
	input  logic [tvn_pkg::CELL_W-1:0]        z,
	output logic signed [tvn_pkg::VAL_W-1:0]  val
);
	import tvn_pkg::*;

	logic [14:0] n;
	logic [27:0] n2;
	logic [55:0] sq_full;
	logic [45:0] inner_full;
	logic [59:0] t_full;
	logic [31:0] t_sum;

	logic [27:0] n_s1, n_s2, n_s3;
	logic [31:0] sq_s2;
	logic [31:0] inner_s3;
	logic signed [VAL_W-1:0] val_s4;

	// Stage 1: lattice index and shift-xor
	assign n  = 15'(x) + 15'(y) * HASH_MUL_Y + 15'(z) * HASH_MUL_Z;
	assign n2 = {n, {HASH_SHIFT{1'b0}}} ^ 28'(n);

	// Stage 2: square, stage 3: polynomial, stage 4: final product
	assign sq_full    = n_s1 * n_s1;
	assign inner_full = sq_s2 * HASH_MUL_SQ;
	assign t_full     = n_s3 * inner_s3;
	assign t_sum      = t_full[31:0] + HASH_ADD_T;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s1     <= n2;
			n_s2     <= n_s1;
			sq_s2    <= sq_full[31:0];
			n_s3     <= n_s2;
			inner_s3 <= inner_full[31:0] + HASH_ADD_SQ;
			val_s4   <= signed'(ONE_Q30 - {1'b0, t_sum[30:0]});
		end
	end

	assign val = val_s4;

endmodule

### rtl/tvn_blend.sv
module tvn_blend (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [tvn_pkg::VAL_W-1:0]  a,
	input  logic signed [tvn_pkg::VAL_W-1:0]  b,
	input  logic [tvn_pkg::WGT_W-1:0]         w,
	output logic signed [tvn_pkg::VAL_W-1:0]  r
);
	import tvn_pkg::*;

	// a + floor((b - a) * w / 2^16), equal to the two-term weighted sum
	logic signed [VAL_W:0]         diff_s1;
	logic signed [VAL_W-1:0]       a_s1;
	logic [WGT_W-1:0]              w_s1;
	logic signed [VAL_W+WGT_W+1:0] prod;
	logic signed [VAL_W-1:0]       r_s2;

	assign prod = diff_s1 * signed'({1'b0, w_s1});

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= (VAL_W+1)'(b) - (VAL_W+1)'(a);
			a_s1    <= a;
			w_s1    <= w;
			r_s2    <= a_s1 + VAL_W'(prod >>> FRAC_W);
		end
	end

	assign r = r_s2;

endmodule

### rtl/tiling_value_noise_voxel.sv
// Periodic 3D value-noise generator: one voxel coordinate in, one noise byte out.
// A request is taken in every cycle in which the pipeline advances, and its result
// passes through 21 register stages, the last of them the result register. The
// pipeline advances as a whole whenever the result register is empty or being
// taken, so noise_ready low with a result waiting stalls every stage. Most of the
// depth comes from the cell/fraction divider (eight stages, up to four quotient bits
// each), the lattice hash multiplies and three two-stage interpolation levels.
// resolution and period are sampled directly by the datapath and must only
// be written while no request is in flight. Reset gives resolution 64, period 4.
module tiling_value_noise_voxel (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [7:0]           cfg_index,
	input  logic [8:0]           cfg_data,
	input  logic                 vox_valid,
	output logic                 vox_ready,
	input  tvn_pkg::vox_t        vox,
	output logic                 noise_valid,
	input  logic                 noise_ready,
	output tvn_pkg::noise_t      noise
);
	import tvn_pkg::*;

	logic [RES_W-1:0] res_q;
	logic [PER_W-1:0] per_q;
	logic             en;

	logic [LAT:1]   vld_s;
	logic [LAT-1:1] oor_s;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_RESET;
			per_q <= PER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_RESOLUTION) res_q <= cfg_data;
			else if (cfg_index == CFG_PERIOD) per_q <= cfg_data[PER_W-1:0];
		end
	end

	// Global advance
	assign en        = !vld_s[LAT] || noise_ready;
	assign vox_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], vox_valid};
		end
	end

	// Stage 1: range check and scaled position
	logic oor_in;
	logic [2:0][POS_W-1:0] pos_s1;

	assign oor_in = (res_q == '0) || ({1'b0, vox.voxel_x} >= res_q)
		|| ({1'b0, vox.voxel_y} >= res_q) || ({1'b0, vox.voxel_z} >= res_q);

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s     <= {oor_s[LAT-2:1], oor_in};
			pos_s1[0] <= POS_W'(vox.voxel_x) * POS_W'(per_q);
			pos_s1[1] <= POS_W'(vox.voxel_y) * POS_W'(per_q);
			pos_s1[2] <= POS_W'(vox.voxel_z) * POS_W'(per_q);
		end
	end

	// Stages 2..9: cell index and fraction per axis
	logic [2:0][QUO_W-1:0] quo;

	for (genvar a = 0; a < 3; a++) begin : g_div
		tvn_div u_div (
			.clk (clk),
			.en  (en),
			.num (pos_s1[a]),
			.den (res_q),
			.quo (quo[a])
		);
	end

	// Stage 10: corner wrap and fraction square
	logic [2:0][CELL_W-1:0] c0_s10, c1_s10;
	logic [2:0][31:0]       ff_s10;
	logic [2:0][17:0]       lin_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				c0_s10[a] <= quo[a][FRAC_W +: CELL_W];
				if ({1'b0, quo[a][FRAC_W +: CELL_W]} + 8'd1 >= {1'b0, per_q})
					c1_s10[a] <= '0;
				else
					c1_s10[a] <= quo[a][FRAC_W +: CELL_W] + CELL_W'(1);
				ff_s10[a]  <= quo[a][FRAC_W-1:0] * quo[a][FRAC_W-1:0];
				lin_s10[a] <= THREE_Q16 - {1'b0, quo[a][FRAC_W-1:0], 1'b0};
			end
		end
	end

	// Stage 11: smoothstep weights, then delayed to their interpolation level
	logic [2:0][49:0]      sw_prod;
	logic [2:0][WGT_W-1:0] wt_s [11:18];

	always_comb begin
		for (int a = 0; a < 3; a++) sw_prod[a] = ff_s10[a] * lin_s10[a];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) wt_s[11][a] <= sw_prod[a][32 +: WGT_W];
			for (int k = 12; k <= 18; k++) wt_s[k] <= wt_s[k-1];
		end
	end

	// Stages 11..14: corner hashes, corner index bit 0 x, bit 1 y, bit 2 z
	logic signed [VAL_W-1:0] corner [8];

	for (genvar c = 0; c < 8; c++) begin : g_hash
		tvn_hash u_hash (
			.clk (clk),
			.en  (en),
			.x   (c[0] ? c1_s10[0] : c0_s10[0]),
			.y   (c[1] ? c1_s10[1] : c0_s10[1]),
			.z   (c[2] ? c1_s10[2] : c0_s10[2]),
			.val (corner[c])
		);
	end

	// Stages 15..20: trilinear interpolation along x, then y, then z
	logic signed [VAL_W-1:0] lx [4];
	logic signed [VAL_W-1:0] ly [2];
	logic signed [VAL_W-1:0] lz;

	for (genvar i = 0; i < 4; i++) begin : g_lx
		tvn_blend u_blend (
			.clk (clk), .en (en),
			.a (corner[2*i]), .b (corner[2*i+1]), .w (wt_s[14][0]), .r (lx[i])
		);
	end

	for (genvar i = 0; i < 2; i++) begin : g_ly
		tvn_blend u_blend (
			.clk (clk), .en (en),
			.a (lx[2*i]), .b (lx[2*i+1]), .w (wt_s[16][1]), .r (ly[i])
		);
	end

	tvn_blend u_blend_z (
		.clk (clk), .en (en),
		.a (ly[0]), .b (ly[1]), .w (wt_s[18][2]), .r (lz)
	);

	// Stage 21: map to byte, result register
	logic [31:0] shifted;
	logic [39:0] scaled;
	logic [8:0]  byte_raw;
	noise_t      out_s21;

	assign shifted  = lz + ONE_Q30;
	assign scaled   = {shifted, 8'd0} - 40'(shifted);
	assign byte_raw = scaled[39:31];

	always_ff @(posedge clk) begin
		if (en) begin
			out_s21.out_of_range <= oor_s[LAT-1];
			if (oor_s[LAT-1])       out_s21.noise_byte <= '0;
			else if (byte_raw[8])   out_s21.noise_byte <= 8'hff;
			else                    out_s21.noise_byte <= byte_raw[7:0];
		end
	end

	assign noise_valid = vld_s[LAT];
	assign noise       = out_s21;

	// Checks
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid && noise.out_of_range |-> noise.noise_byte == 8'd0)
		else $error("out-of-range result with non-zero byte");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!noise_valid |-> vox_ready)
		else $error("request refused with empty result register");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		noise_valid && !noise_ready |-> !vox_ready)
		else $error("request taken during stall");

endmodule

### tb/sv/tvn_checker.sv
// Watches the voxel and noise channels, predicts each noise byte and compares.
module tvn_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [7:0]        cfg_index,
	input  logic [8:0]        cfg_data,
	input  logic              vox_valid,
	input  logic              vox_ready,
	input  tvn_pkg::vox_t     vox,
	input  logic              noise_valid,
	input  logic              noise_ready,
	input  tvn_pkg::noise_t   noise,
	output int                fail_count,
	output int                pending
);
	import tvn_pkg::*;

	localparam int EXP_DEPTH = 256;

	logic [8:0] res_q;
	logic [6:0] per_q;
	noise_t     exp_mem [EXP_DEPTH];
	int         wr_ptr, rd_ptr;

	assign pending = wr_ptr - rd_ptr;

	// Corner value in Q2.30: 2^30 minus the 31-bit lattice hash
	function automatic longint corner_value(input int unsigned x, input int unsigned y,
			input int unsigned z);
		logic [31:0] n, sq, inner, t;
		n = x + y * 57 + z * 113;
		n = (n << 13) ^ n;
		sq = n * n;
		inner = sq * 32'd15731 + 32'd789221;
		t = n * inner + 32'd1376312589;
		return 64'sd1073741824 - longint'({33'd0, t[30:0]});
	endfunction

	// Linear blend with floor division by 2^16
	function automatic longint mix16(input longint a, input longint b, input longint w);
		return (a * (65536 - w) + b * w) >>> 16;
	endfunction

	function automatic noise_t predict_noise(input vox_t v);
		noise_t r;
		int unsigned c[3], cell_idx[3], fr[3], lo[3], hi[3], p;
		longint wt[3], c00, c10, c01, c11, n0, n1, nv;
		longint unsigned ff, lin;
		c[0] = v.voxel_x; c[1] = v.voxel_y; c[2] = v.voxel_z;
		r = '0;
		if (res_q == 0 || c[0] >= res_q || c[1] >= res_q || c[2] >= res_q) begin
			r.out_of_range = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			p = c[i] * per_q;
			cell_idx[i] = p / res_q;
			fr[i] = ((p % res_q) << 16) / res_q;
			ff = longint'(fr[i]) * fr[i];
			lin = 3 * 65536 - 2 * fr[i];
			wt[i] = (ff * lin) >> 32;
			lo[i] = (per_q == 0) ? 0 : cell_idx[i] % per_q;
			hi[i] = (per_q == 0) ? 0 : (cell_idx[i] + 1) % per_q;
		end
		c00 = mix16(corner_value(lo[0], lo[1], lo[2]), corner_value(hi[0], lo[1], lo[2]), wt[0]);
		c10 = mix16(corner_value(lo[0], hi[1], lo[2]), corner_value(hi[0], hi[1], lo[2]), wt[0]);
		c01 = mix16(corner_value(lo[0], lo[1], hi[2]), corner_value(hi[0], lo[1], hi[2]), wt[0]);
		c11 = mix16(corner_value(lo[0], hi[1], hi[2]), corner_value(hi[0], hi[1], hi[2]), wt[0]);
		n0 = mix16(c00, c10, wt[1]);
		n1 = mix16(c01, c11, wt[1]);
		nv = mix16(n0, n1, wt[2]);
		nv = ((nv + 64'sd1073741824) * 255) >>> 31;
		r.noise_byte = (nv > 255) ? 8'd255 : nv[7:0];
		return r;
	endfunction

	// Track registers, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		noise_t e;
		int     errs;
		errs = 0;
		if (!arst_n) begin
			res_q <= RES_RESET;
			per_q <= PER_RESET;
			fail_count <= 0;
			wr_ptr <= 0;
			rd_ptr <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_RESOLUTION) res_q <= cfg_data;
				else if (cfg_index == CFG_PERIOD) per_q <= cfg_data[6:0];
			end
			if (vox_valid && vox_ready) begin
				exp_mem[wr_ptr % EXP_DEPTH] <= predict_noise(vox);
				wr_ptr <= wr_ptr + 1;
			end
			if (noise_valid && noise_ready) begin
				if (wr_ptr == rd_ptr) begin
					$error("noise result with no request waiting");
					errs = errs + 1;
				end else begin
					e = exp_mem[rd_ptr % EXP_DEPTH];
					rd_ptr <= rd_ptr + 1;
					if (e.noise_byte !== noise.noise_byte) begin
						$error("noise_byte expected %0d actual %0d", e.noise_byte,
							noise.noise_byte);
						errs = errs + 1;
					end
					if (e.out_of_range !== noise.out_of_range) begin
						$error("out_of_range expected %0d actual %0d", e.out_of_range,
							noise.out_of_range);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end
endmodule

### tb/sv/tiling_value_noise_voxel_test.sv
module tiling_value_noise_voxel_test;
	import tvn_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;
	logic vox_valid = 1'b0;
	logic vox_ready;
	vox_t vox = '0;
	logic noise_valid;
	logic noise_ready = 1'b0;
	noise_t noise;
	int fail_count, pending;
	int cur_res = 64;
	bit hold_off = 1'b0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	tiling_value_noise_voxel DUT (.*);

	tvn_checker checker_inst (.*);

	// Watchdog on cycles with no accepted request, result or configuration write
	always @(posedge clk) begin
		if ((vox_valid && vox_ready) || (noise_valid && noise_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("tiling_value_noise_voxel_test NOT OK");
			$finish;
		end
	end

	// Receiver: random stall per result, or a long hold-off on request
	initial begin
		int gap;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_off) begin
				noise_ready <= 1'b0;
				repeat (120) @(posedge clk);
				hold_off = 1'b0;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				noise_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			noise_ready <= 1'b1;
			@(posedge clk iff noise_valid);
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk iff cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_RESOLUTION) cur_res = val;
	endtask

	task automatic drain;
		@(posedge clk iff pending == 0);
		repeat (LAT + 4) @(posedge clk);
	endtask

	task automatic send_voxel(input logic [7:0] x, y, z, input bit stall);
		int gap;
		gap = stall ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			vox_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vox_valid <= 1'b1;
		vox <= '{voxel_x: x, voxel_y: y, voxel_z: z};
		@(posedge clk iff vox_ready);
	endtask

	function automatic logic [7:0] pick_coord;
		int lim;
		lim = (cur_res > 256) ? 256 : cur_res;
		if (lim == 0 || $urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, lim - 1));
	endfunction

	task automatic random_voxels(input int count);
		bit burst;
		burst = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) burst = $urandom_range(0, 2) == 0;
			send_voxel(pick_coord(), pick_coord(), pick_coord(), !burst);
		end
		vox_valid <= 1'b0;
	endtask

	initial begin
		int res_set[8];
		int per_set[8];
		res_set = '{64, 1, 256, 255, 0, 300, 7, 100};
		per_set = '{4, 1, 64, 127, 0, 17, 3, 2};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, field extremes and out of range
		send_voxel(8'd0, 8'd0, 8'd0, 1'b0);
		send_voxel(8'd63, 8'd63, 8'd63, 1'b0);
		send_voxel(8'd64, 8'd0, 8'd0, 1'b0);
		send_voxel(8'd0, 8'd64, 8'd0, 1'b0);
		send_voxel(8'd0, 8'd0, 8'd255, 1'b0);
		send_voxel(8'd255, 8'd255, 8'd255, 1'b0);
		send_voxel(8'd15, 8'd16, 8'd17, 1'b0);
		send_voxel(8'd170, 8'd85, 8'd31, 1'b0);
		vox_valid <= 1'b0;
		drain();
		write_reg(CFG_RESOLUTION, 9'd256);
		write_reg(CFG_PERIOD, 9'd127);
		send_voxel(8'd255, 8'd255, 8'd255, 1'b0);
		send_voxel(8'd128, 8'd1, 8'd254, 1'b0);
		vox_valid <= 1'b0;
		drain();
		write_reg(CFG_PERIOD, 9'd0);
		write_reg(cfg_idx_t'(8'd7), 9'd511);
		send_voxel(8'd200, 8'd3, 8'd99, 1'b0);
		vox_valid <= 1'b0;
		drain();
		write_reg(CFG_RESOLUTION, 9'd0);
		send_voxel(8'd0, 8'd0, 8'd0, 1'b0);
		vox_valid <= 1'b0;
		drain();

		// Long receiver hold-off while requests keep coming
		write_reg(CFG_RESOLUTION, 9'd64);
		write_reg(CFG_PERIOD, 9'd4);
		hold_off = 1'b1;
		for (int i = 0; i < 60; i++) send_voxel(pick_coord(), pick_coord(), pick_coord(), 1'b0);
		vox_valid <= 1'b0;
		drain();

		// Random phases over several settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(CFG_RESOLUTION, 9'(res_set[ph]));
			write_reg(CFG_PERIOD, 9'(per_set[ph]));
			random_voxels(190);
			drain();
		end

		if (fail_count == 0)
			$display("tiling_value_noise_voxel_test OK");
		else
			$display("tiling_value_noise_voxel_test NOT OK");
		$finish;
	end
endmodule

### tiling_value_noise_voxel.f
rtl/tvn_pkg.sv
rtl/tvn_div.sv
rtl/tvn_hash.sv
rtl/tvn_blend.sv
rtl/tiling_value_noise_voxel.sv
tb/sv/tvn_checker.sv
tb/sv/tiling_value_noise_voxel_test.sv
